@@ sv/vlt_pkg.sv @@
// ---------------------------------------------------------------------------
// vlt_pkg: shared types and constants of the versioned lock table
// Command and status codes, request and reply records, table sizing.
// ---------------------------------------------------------------------------
package vlt_pkg;

    localparam int KEY_COUNT    = 16;
    localparam int KEY_IW       = $clog2(KEY_COUNT);
    localparam int KEY_W        = 4;
    localparam int CLIENT_W     = 4;
    localparam int VALUE_W      = 64;
    localparam int VALUE_BITS   = 64;
    localparam int VERSION_W    = 31;
    localparam int SEQ_W        = 32;
    localparam int RVER_W       = 32;
    localparam int INITIAL_KEYS = 5;

    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);

    typedef enum logic [2:0] {
        CMD_GET    = 3'd0,
        CMD_LOCK   = 3'd1,
        CMD_PUT    = 3'd2,
        CMD_UPDATE = 3'd3,
        CMD_UNLOCK = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_UNDEF   = 2'd2
    } t_status;

    localparam logic [RVER_W-1:0] VER_MINUS_ONE = {RVER_W{1'b1}};
    localparam logic [RVER_W-1:0] VER_NULL_GET  = RVER_W'(1);

    typedef struct packed {
        logic [2:0]           cmd;
        logic [KEY_W-1:0]     key;
        logic [CLIENT_W-1:0]  client;
        logic [VALUE_W-1:0]   value;
        logic [VERSION_W-1:0] version;
        logic [SEQ_W-1:0]     seq;
    } t_req;

    typedef struct packed {
        logic [2:0]                kind;
        logic [KEY_W-1:0]          key;
        logic [SEQ_W-1:0]          seq;
        t_status                   status;
        logic [VALUE_W-1:0]        value;
        logic                      value_null;
        logic signed [RVER_W-1:0]  version;
    } t_rsp;

endpackage

@@ sv/vlt_table.sv @@
// ---------------------------------------------------------------------------
// vlt_table: entry storage and per-request read-modify-write
// Decodes one request against its entry, builds the reply, updates state.
// ---------------------------------------------------------------------------
module vlt_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  vlt_pkg::t_req i_req,
    output logic          o_has_reply,
    output vlt_pkg::t_rsp o_rsp
);
    import vlt_pkg::*;

    logic                 r_present  [KEY_COUNT];
    logic [VALUE_W-1:0]   r_value    [KEY_COUNT];
    logic [VERSION_W-1:0] r_version  [KEY_COUNT];
    logic                 r_lock     [KEY_COUNT];
    logic [CLIENT_W-1:0]  r_lock_own [KEY_COUNT];
    logic                 r_resv     [KEY_COUNT];
    logic [CLIENT_W-1:0]  r_resv_own [KEY_COUNT];

    logic [KEY_IW-1:0]  idx;
    logic               inr;
    logic               present;
    logic               locked;
    logic               lock_mine;
    logic               resv;
    logic               resv_mine;
    logic               newer;
    logic [VALUE_W-1:0] req_value;

    logic wr_data;
    logic set_present;
    logic set_lock;
    logic clr_lock;
    logic set_resv;
    logic clr_resv;

    assign idx       = i_req.key[KEY_IW-1:0];
    assign inr       = 32'(i_req.key) < KEY_COUNT;
    assign present   = inr && r_present[idx];
    assign locked    = r_lock[idx];
    assign lock_mine = r_lock_own[idx] == i_req.client;
    assign resv      = inr && r_resv[idx];
    assign resv_mine = r_resv_own[idx] == i_req.client;
    assign newer     = r_version[idx] < i_req.version;
    assign req_value = i_req.value & VALUE_MASK;

    // decode: state changes and reply for the entry under this request
    always_comb begin
        wr_data     = 1'b0;
        set_present = 1'b0;
        set_lock    = 1'b0;
        clr_lock    = 1'b0;
        set_resv    = 1'b0;
        clr_resv    = 1'b0;
        o_has_reply = 1'b1;

        o_rsp.kind       = i_req.cmd;
        o_rsp.key        = i_req.key;
        o_rsp.seq        = i_req.seq;
        o_rsp.status     = ST_OK;
        o_rsp.value      = '0;
        o_rsp.value_null = 1'b0;
        o_rsp.version    = '0;

        case (i_req.cmd)
            CMD_GET: begin
                if (present && !locked) begin
                    o_rsp.value   = r_value[idx];
                    o_rsp.version = {1'b0, r_version[idx]};
                end else if (present) begin
                    o_rsp.status  = ST_REFUSED;
                    o_rsp.version = VER_MINUS_ONE;
                end else begin
                    o_rsp.value_null = 1'b1;
                    o_rsp.version    = VER_NULL_GET;
                end
            end
            CMD_LOCK: begin
                if (present && !locked) begin
                    set_lock      = 1'b1;
                    o_rsp.value   = req_value;
                    o_rsp.version = {1'b0, r_version[idx]};
                end else if (!present && inr && !resv) begin
                    set_resv      = 1'b1;
                    o_rsp.value   = req_value;
                    o_rsp.version = VER_MINUS_ONE;
                end else begin
                    o_rsp.status  = ST_REFUSED;
                    o_rsp.version = VER_MINUS_ONE;
                end
            end
            CMD_PUT: begin
                o_has_reply = 1'b0;
                if (present && locked && lock_mine) begin
                    clr_lock = 1'b1;
                    wr_data  = newer;
                end else if (resv && resv_mine) begin
                    set_present = 1'b1;
                    wr_data     = 1'b1;
                    clr_lock    = 1'b1;
                    clr_resv    = 1'b1;
                end
            end
            CMD_UPDATE: begin
                o_has_reply = 1'b0;
                wr_data     = present && !locked && newer;
            end
            CMD_UNLOCK: begin
                o_has_reply = 1'b0;
                if (present && locked && lock_mine) begin
                    clr_lock = 1'b1;
                    clr_resv = resv && resv_mine;
                end
            end
            default: begin
                o_rsp.status = ST_UNDEF;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_present[k]  <= k < INITIAL_KEYS;
                r_value[k]    <= '0;
                r_version[k]  <= '0;
                r_lock[k]     <= 1'b0;
                r_lock_own[k] <= '0;
                r_resv[k]     <= 1'b0;
                r_resv_own[k] <= '0;
            end
        end else if (i_fire && inr) begin
            if (set_present) begin
                r_present[idx] <= 1'b1;
            end
            if (wr_data) begin
                r_value[idx]   <= req_value;
                r_version[idx] <= i_req.version;
            end
            if (set_lock) begin
                r_lock[idx]     <= 1'b1;
                r_lock_own[idx] <= i_req.client;
            end else if (clr_lock) begin
                r_lock[idx] <= 1'b0;
            end
            if (set_resv) begin
                r_resv[idx]     <= 1'b1;
                r_resv_own[idx] <= i_req.client;
            end else if (clr_resv) begin
                r_resv[idx] <= 1'b0;
            end
        end
    end

endmodule

@@ sv/versioned_lock_table_unit.sv @@
// ---------------------------------------------------------------------------
// versioned_lock_table_unit: versioned lock table, top level
// Request register, table read-modify-write, reply register.
// ---------------------------------------------------------------------------
// a request waits in the request register; when it retires, any reply it makes is written into the reply register
// throughput: one request per cycle unless the reply register stalls; put, update and unlock retire with no reply
// the only stall source is a full reply register held by i_out_stall
// reset (synchronous, active low) empties both registers and restores the
// table: first five keys present, all values and versions zero, no locks,
// no reservations
module versioned_lock_table_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_cmd,
    input  logic [vlt_pkg::KEY_W-1:0]           i_key,
    input  logic [vlt_pkg::CLIENT_W-1:0]        i_client,
    input  logic [vlt_pkg::VALUE_W-1:0]         i_value,
    input  logic [vlt_pkg::VERSION_W-1:0]       i_version,
    input  logic [vlt_pkg::SEQ_W-1:0]           i_seq,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_reply_kind,
    output logic [vlt_pkg::KEY_W-1:0]           o_reply_key,
    output logic [vlt_pkg::SEQ_W-1:0]           o_reply_seq,
    output logic [1:0]                          o_status,
    output logic [vlt_pkg::VALUE_W-1:0]         o_reply_value,
    output logic                                o_value_null,
    output logic signed [vlt_pkg::RVER_W-1:0]   o_reply_version
);
    import vlt_pkg::*;

    // request stage
    logic r_req_valid;
    logic n_req_valid;
    t_req r_req;

    // reply stage
    logic r_out_valid;
    logic n_out_valid;
    t_rsp r_out;

    logic in_accept;
    logic req_fire;
    logic has_reply;
    t_rsp rsp;

    vlt_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (req_fire),
        .i_req       (r_req),
        .o_has_reply (has_reply),
        .o_rsp       (rsp)
    );

    // the held request retires when it makes no reply, or when the reply
    // register is empty or being drained this cycle
    assign req_fire   = r_req_valid && (!has_reply || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_req_valid && !req_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_req_valid = r_req_valid;
        if (in_accept) begin
            n_req_valid = 1'b1;
        end else if (req_fire) begin
            n_req_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (req_fire && has_reply) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_req_valid <= n_req_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req.cmd     <= i_cmd;
            r_req.key     <= i_key;
            r_req.client  <= i_client;
            r_req.value   <= i_value;
            r_req.version <= i_version;
            r_req.seq     <= i_seq;
        end
        if (req_fire && has_reply) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_reply_kind    = r_out.kind;
    assign o_reply_key     = r_out.key;
    assign o_reply_seq     = r_out.seq;
    assign o_status        = r_out.status;
    assign o_reply_value   = r_out.value;
    assign o_value_null    = r_out.value_null;
    assign o_reply_version = r_out.version;

endmodule

@@ sv/vlt_checker.sv @@
// ---------------------------------------------------------------------------
// vlt_checker: port-level checks of the versioned lock table
// Reply channel handshake and reply field consistency.
// ---------------------------------------------------------------------------
module vlt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [2:0]                         o_reply_kind,
    input logic [vlt_pkg::SEQ_W-1:0]          o_reply_seq,
    input logic [1:0]                         o_status,
    input logic [vlt_pkg::VALUE_W-1:0]        o_reply_value,
    input logic                               o_value_null,
    input logic signed [vlt_pkg::RVER_W-1:0]  o_reply_version
);
    import vlt_pkg::*;

    // stalled reply stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("reply dropped while stalled");

    // stalled reply payload unchanged
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_reply_seq) && $stable(o_status) && $stable(o_reply_value))
        else $error("reply payload changed while stalled");

    // only get, lock and undefined commands reply; undefined status matches kind
    a_reply_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_reply_kind != CMD_PUT && o_reply_kind != CMD_UPDATE &&
            o_reply_kind != CMD_UNLOCK &&
            ((o_status == ST_UNDEF) ==
             (o_reply_kind != CMD_GET && o_reply_kind != CMD_LOCK)))
        else $error("reply kind and status disagree");

    // null flag only on a successful get, with version one and no data
    a_null_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_value_null |->
            o_reply_kind == CMD_GET && o_status == ST_OK &&
            o_reply_version == VER_NULL_GET && o_reply_value == '0)
        else $error("bad null reply");

    // refused replies carry version minus one and no data
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_REFUSED |->
            o_reply_version == VER_MINUS_ONE && o_reply_value == '0 && !o_value_null)
        else $error("bad refused reply");

endmodule

bind versioned_lock_table_unit vlt_checker u_vlt_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: versioned lock table unit
// Walks a short table of hand-picked requests, then mostly well-formed
// lock / put / unlock sequences with random content and some noise. Every
// accepted request runs through a private model of the table; replies are
// checked field by field against the oldest expectation in order.
// ---------------------------------------------------------------------------
module testbench;
    import vlt_pkg::*;

    // spare command codes, all of them replied to as undefined
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    localparam int RANDOM_ITEMS = 1600;
    localparam int NO_PROGRESS_LIMIT = 5000;  // well above the long hold-off
    localparam int DRAIN_CYCLES = 8;          // idle wait after the last expected reply
    localparam int HOLD_START = 700;          // receiver hold-off, in its own cycles
    localparam int HOLD_LEN = 300;
    localparam int RX_CALM_START = 1200;      // receiver never stalls here
    localparam int RX_CALM_LEN = 400;
    localparam int TX_CALM_FIRST = 600;       // sender never idles for these requests
    localparam int TX_CALM_LAST = 900;

    // dut ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [2:0]                 i_cmd = '0;
    logic [KEY_W-1:0]           i_key = '0;
    logic [CLIENT_W-1:0]        i_client = '0;
    logic [VALUE_W-1:0]         i_value = '0;
    logic [VERSION_W-1:0]       i_version = '0;
    logic [SEQ_W-1:0]           i_seq = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [2:0]                 o_reply_kind;
    logic [KEY_W-1:0]           o_reply_key;
    logic [SEQ_W-1:0]           o_reply_seq;
    logic [1:0]                 o_status;
    logic [VALUE_W-1:0]         o_reply_value;
    logic                       o_value_null;
    logic signed [RVER_W-1:0]   o_reply_version;

    versioned_lock_table_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_key           (i_key),
        .i_client        (i_client),
        .i_value         (i_value),
        .i_version       (i_version),
        .i_seq           (i_seq),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reply_kind    (o_reply_kind),
        .o_reply_key     (o_reply_key),
        .o_reply_seq     (o_reply_seq),
        .o_status        (o_status),
        .o_reply_value   (o_reply_value),
        .o_value_null    (o_value_null),
        .o_reply_version (o_reply_version)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // private copy of the table
    // ------------------------------------------------------------------
    logic                   tbl_present   [KEY_COUNT];
    logic [VALUE_W-1:0]     tbl_value     [KEY_COUNT];
    logic [VERSION_W-1:0]   tbl_version   [KEY_COUNT];
    logic                   tbl_locked    [KEY_COUNT];
    logic [CLIENT_W-1:0]    tbl_lock_own  [KEY_COUNT];
    logic                   tbl_reserved  [KEY_COUNT];
    logic [CLIENT_W-1:0]    tbl_res_own   [KEY_COUNT];

    t_rsp pending_replies[$];   // expected replies, oldest first
    int   fail_count = 0;
    int   items_sent = 0;

    // directed rows: a request, and where obvious its reply typed in
    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_dir_row;

    t_dir_row dir_rows[$];

    function automatic void clear_table();
        for (int k = 0; k < KEY_COUNT; k++) begin
            tbl_present[k]  = (k < INITIAL_KEYS);
            tbl_value[k]    = '0;
            tbl_version[k]  = '0;
            tbl_locked[k]   = 1'b0;
            tbl_lock_own[k] = '0;
            tbl_reserved[k] = 1'b0;
            tbl_res_own[k]  = '0;
        end
    endfunction

    // apply one request to the table copy; returns 1 when it earns a reply
    function automatic bit table_access(input t_req r, output t_rsp rsp);
        logic [VALUE_W-1:0] val;
        logic [KEY_W-1:0]   k;
        logic               present;
        val     = r.value & VALUE_MASK;
        k       = r.key;
        present = tbl_present[k];
        rsp        = '0;
        rsp.kind   = r.cmd;
        rsp.key    = r.key;
        rsp.seq    = r.seq;
        rsp.status = ST_OK;
        case (r.cmd)
            CMD_PUT: begin
                if (present && tbl_locked[k] && tbl_lock_own[k] == r.client) begin
                    // owner releases, writing only a strictly newer version
                    if (tbl_version[k] < r.version) begin
                        tbl_value[k]   = val;
                        tbl_version[k] = r.version;
                    end
                    tbl_locked[k] = 1'b0;
                end else if (tbl_reserved[k] && tbl_res_own[k] == r.client) begin
                    // reserver creates the entry, any version goes
                    tbl_present[k]  = 1'b1;
                    tbl_value[k]    = val;
                    tbl_version[k]  = r.version;
                    tbl_locked[k]   = 1'b0;
                    tbl_reserved[k] = 1'b0;
                end
                return 1'b0;
            end
            CMD_UPDATE: begin
                if (present && !tbl_locked[k] && tbl_version[k] < r.version) begin
                    tbl_value[k]   = val;
                    tbl_version[k] = r.version;
                end
                return 1'b0;
            end
            CMD_UNLOCK: begin
                if (present && tbl_locked[k] && tbl_lock_own[k] == r.client) begin
                    if (tbl_reserved[k] && tbl_res_own[k] == r.client)
                        tbl_reserved[k] = 1'b0;
                    tbl_locked[k] = 1'b0;
                end
                return 1'b0;
            end
            CMD_GET: begin
                if (present && !tbl_locked[k]) begin
                    rsp.value   = tbl_value[k];
                    rsp.version = {1'b0, tbl_version[k]};
                end else if (present) begin
                    rsp.status  = ST_REFUSED;
                    rsp.version = VER_MINUS_ONE;
                end else begin
                    rsp.value_null = 1'b1;
                    rsp.version    = VER_NULL_GET;
                end
            end
            CMD_LOCK: begin
                if (present && !tbl_locked[k]) begin
                    tbl_locked[k]   = 1'b1;
                    tbl_lock_own[k] = r.client;
                    rsp.value       = val;
                    rsp.version     = {1'b0, tbl_version[k]};
                end else if (!present && !tbl_reserved[k]) begin
                    // absent key: reserve once, no version yet
                    tbl_reserved[k] = 1'b1;
                    tbl_res_own[k]  = r.client;
                    rsp.value       = val;
                    rsp.version     = VER_MINUS_ONE;
                end else begin
                    rsp.status  = ST_REFUSED;
                    rsp.version = VER_MINUS_ONE;
                end
            end
            default: rsp.status = ST_UNDEF;
        endcase
        return 1'b1;
    endfunction

    function automatic t_req mk_req(logic [2:0] cmd, logic [KEY_W-1:0] key,
                                    logic [CLIENT_W-1:0] client, logic [VALUE_W-1:0] value,
                                    logic [VERSION_W-1:0] version, logic [SEQ_W-1:0] seq);
        t_req r;
        r.cmd     = cmd;
        r.key     = key;
        r.client  = client;
        r.value   = value;
        r.version = version;
        r.seq     = seq;
        return r;
    endfunction

    // queue a directed row; typed replies echo kind, key and seq of the request
    function automatic void add_row(t_req r, bit typed = 1'b0, t_status st = ST_OK,
                                    logic [VALUE_W-1:0] v = '0, logic nul = 1'b0,
                                    logic [RVER_W-1:0] ver = '0);
        t_dir_row row;
        row.req            = r;
        row.typed          = typed;
        row.rsp            = '0;
        row.rsp.kind       = r.cmd;
        row.rsp.key        = r.key;
        row.rsp.seq        = r.seq;
        row.rsp.status     = st;
        row.rsp.value      = v;
        row.rsp.value_null = nul;
        row.rsp.version    = ver;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    // mostly just newer than the entry, sometimes stale, sometimes anything
    function automatic logic [VERSION_W-1:0] rand_version(logic [KEY_W-1:0] k);
        case ($urandom_range(0, 9))
            0, 1:    return VERSION_W'($urandom);
            2, 3:    return tbl_version[k] - VERSION_W'($urandom_range(0, 3));
            default: return tbl_version[k] + VERSION_W'($urandom_range(1, 4));
        endcase
    endfunction

    // offer one request and hold it until accepted, then predict its reply
    task automatic send_req(t_req r, bit typed = 1'b0, t_rsp typed_rsp = '0);
        t_rsp rsp;
        bool_gap: begin
            if (!(items_sent >= TX_CALM_FIRST && items_sent < TX_CALM_LAST)
                && $urandom_range(0, 99) < 12) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_cmd      <= r.cmd;
        i_key      <= r.key;
        i_client   <= r.client;
        i_value    <= r.value;
        i_version  <= r.version;
        i_seq      <= r.seq;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        if (table_access(r, rsp))
            pending_replies.push_back(typed ? typed_rsp : rsp);
        items_sent++;
    endtask

    task automatic run_random();
        logic [KEY_W-1:0]    k;
        logic [CLIENT_W-1:0] c;
        logic [CLIENT_W-1:0] other;
        int                  pick;
        while (items_sent < RANDOM_ITEMS) begin
            k     = KEY_W'($urandom_range(0, KEY_COUNT - 1));
            c     = CLIENT_W'($urandom);
            other = c ^ CLIENT_W'($urandom_range(1, 15));
            pick  = $urandom_range(0, 99);
            if (pick < 45) begin
                // well formed: lock, maybe a peek by someone else, release
                send_req(mk_req(CMD_LOCK, k, c, rand_value(), rand_version(k), $urandom));
                if ($urandom_range(0, 2) == 0)
                    send_req(mk_req(CMD_GET, k, other, rand_value(), rand_version(k),
                                    $urandom));
                if ($urandom_range(0, 3) == 0)
                    send_req(mk_req(CMD_UNLOCK, k, c, rand_value(), rand_version(k),
                                    $urandom));
                else
                    send_req(mk_req(CMD_PUT, k, c, rand_value(), rand_version(k),
                                    $urandom));
            end else if (pick < 60) begin
                send_req(mk_req(CMD_UPDATE, k, c, rand_value(), rand_version(k), $urandom));
            end else if (pick < 75) begin
                send_req(mk_req(CMD_GET, k, c, rand_value(), rand_version(k), $urandom));
            end else if (pick < 88) begin
                // broken: a foreign client tries to release or write
                send_req(mk_req(CMD_LOCK, k, c, rand_value(), rand_version(k), $urandom));
                send_req(mk_req($urandom_range(0, 1) ? CMD_PUT : CMD_UNLOCK, k, other,
                                rand_value(), rand_version(k), $urandom));
            end else begin
                // noise, spare codes included
                send_req(mk_req(3'($urandom_range(0, 7)), KEY_W'($urandom),
                                CLIENT_W'($urandom), rand_value(),
                                VERSION_W'($urandom), $urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence: reset, directed table, random part, drain
    // ------------------------------------------------------------------
    initial begin
        clear_table();
        // from reset: keys 0..4 present at version 0, the rest absent
        add_row(mk_req(CMD_GET, 0, 0, '1, '1, 32'h0), 1, ST_OK, '0, 1'b0, '0);
        add_row(mk_req(CMD_GET, 15, 15, '0, '0, 32'hffff_ffff), 1, ST_OK, '0, 1'b1,
                VER_NULL_GET);
        // extreme version, then the same version again is not newer
        add_row(mk_req(CMD_UPDATE, 0, 0, '1, 31'h7fff_ffff, 32'h1));
        add_row(mk_req(CMD_UPDATE, 0, 0, '0, 31'h7fff_ffff, 32'h2));
        add_row(mk_req(CMD_GET, 0, 8, '0, '0, 32'h3));
        // lock, refusals while locked, foreign put, owner put with newer version
        add_row(mk_req(CMD_LOCK, 1, 15, 64'h0123_4567_89ab_cdef, '0, 32'h4), 1, ST_OK,
                64'h0123_4567_89ab_cdef, 1'b0, '0);
        add_row(mk_req(CMD_GET, 1, 0, '0, '0, 32'h5), 1, ST_REFUSED, '0, 1'b0,
                VER_MINUS_ONE);
        add_row(mk_req(CMD_LOCK, 1, 3, '1, '0, 32'h6), 1, ST_REFUSED, '0, 1'b0,
                VER_MINUS_ONE);
        add_row(mk_req(CMD_UPDATE, 1, 15, '1, 31'd9, 32'h7));
        add_row(mk_req(CMD_PUT, 1, 3, '1, 31'd9, 32'h8));
        add_row(mk_req(CMD_PUT, 1, 15, 64'hdead_beef_cafe_f00d, 31'd5, 32'h9));
        add_row(mk_req(CMD_GET, 1, 2, '0, '0, 32'ha));
        // owner put with a version that is not newer only unlocks
        add_row(mk_req(CMD_LOCK, 3, 7, 64'h55, '0, 32'hb), 1, ST_OK, 64'h55, 1'b0, '0);
        add_row(mk_req(CMD_PUT, 3, 7, '1, '0, 32'hc));
        // unlock by a stranger is ignored, by the owner it frees the entry
        add_row(mk_req(CMD_LOCK, 2, 1, 64'haaaa_5555_aaaa_5555, '0, 32'hd));
        add_row(mk_req(CMD_UNLOCK, 2, 2, '0, '0, 32'he));
        add_row(mk_req(CMD_UNLOCK, 2, 1, '0, '0, 32'hf));
        add_row(mk_req(CMD_GET, 2, 9, '0, '0, 32'h10));
        // absent key: reserve, second reserve refused even for the same client
        add_row(mk_req(CMD_LOCK, 9, 4, 64'h8000_0000_0000_0001, '0, 32'h11), 1, ST_OK,
                64'h8000_0000_0000_0001, 1'b0, VER_MINUS_ONE);
        add_row(mk_req(CMD_LOCK, 9, 4, '1, '0, 32'h12), 1, ST_REFUSED, '0, 1'b0,
                VER_MINUS_ONE);
        add_row(mk_req(CMD_PUT, 9, 5, '1, 31'd3, 32'h13));
        add_row(mk_req(CMD_PUT, 9, 4, 64'h0f0f_0f0f_0f0f_0f0f, '0, 32'h14));
        add_row(mk_req(CMD_GET, 9, 0, '0, '0, 32'h15));
        // spare command codes
        add_row(mk_req(CMD_SPARE_A, 4, 1, '1, '1, 32'h16), 1, ST_UNDEF, '0, 1'b0, '0);
        add_row(mk_req(CMD_SPARE_B, 0, 2, '1, '1, 32'h17), 1, ST_UNDEF, '0, 1'b0, '0);
        add_row(mk_req(CMD_SPARE_C, 15, 15, '1, '1, 32'h18), 1, ST_UNDEF, '0, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        run_random();
        i_in_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, one long hold-off, one calm stretch
    // ------------------------------------------------------------------
    initial begin
        int rx_cycle;
        rx_cycle = 0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                i_out_stall <= 1'b1;   // fill the block so it stalls its request side
            else if (rx_cycle >= RX_CALM_START && rx_cycle < RX_CALM_START + RX_CALM_LEN)
                i_out_stall <= 1'b0;
            else
                i_out_stall <= ($urandom_range(0, 99) < 12);
        end
    end

    // ------------------------------------------------------------------
    // reply checker: compare each accepted reply with the oldest expectation
    // ------------------------------------------------------------------
    t_rsp want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected reply: kind %0d key %0d seq %h", o_reply_kind,
                             o_reply_key, o_reply_seq);
            end else begin
                want = pending_replies.pop_front();
                if (o_reply_kind !== want.kind || o_reply_key !== want.key
                    || o_reply_seq !== want.seq || o_status !== want.status
                    || o_reply_value !== want.value || o_value_null !== want.value_null
                    || o_reply_version !== want.version) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display(
                            "expected: kind %0d key %0d seq %h st %0d val %h null %0b ver %0d",
                            want.kind, want.key, want.seq, want.status, want.value,
                            want.value_null, $signed(want.version));
                        $display(
                            "  actual: kind %0d key %0d seq %h st %0d val %h null %0b ver %0d",
                            o_reply_kind, o_reply_key, o_reply_seq, o_status,
                            o_reply_value, o_value_null, o_reply_version);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any request or reply moving ends the run
    // ------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge i_rst_n);
        while (idle_cycles < NO_PROGRESS_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no progress, %0d replies still outstanding",
                 pending_replies.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ versioned_lock_table_unit.f @@
sv/vlt_pkg.sv
sv/vlt_table.sv
sv/versioned_lock_table_unit.sv
sv/vlt_checker.sv
dv/testbench.sv
